>>> sv/pdtv_pkg.sv
// ----------------------------------------------------------------------------
// pdtv_pkg: shared types, constants and functions of the datetime validator
//
// Holds the pipeline geometry, the binary-to-BCD chunk converter used by each
// conversion stage, and the range check applied to the final BCD digits.
// ----------------------------------------------------------------------------
package pdtv_pkg;

   // Input word width and the bit that is ignored (sign marker).
   localparam int WORD_W     = 64;
   localparam int SIGN_BIT   = 63;

   // Only the low fourteen decimal digits (YYYYMMDDhhmmss) matter.
   localparam int DIGITS     = 14;
   localparam int BCD_W      = 4 * DIGITS;

   // Conversion stages: each one shifts in a chunk of input bits.
   localparam int STAGE_BITS = 8;
   localparam int NUM_STAGES = WORD_W / STAGE_BITS;

   // Cycles from the accepting edge to the edge that takes the result.
   localparam int LATENCY    = NUM_STAGES + 2;

   // Digit positions (units digit of each two-digit group).
   localparam int SEC_POS    = 0;
   localparam int MIN_POS    = 2;
   localparam int HOUR_POS   = 4;
   localparam int DAY_POS    = 6;
   localparam int MONTH_POS  = 8;
   localparam int YEAR_POS   = 10;

   typedef logic [BCD_W-1:0]      bcd_type;
   typedef logic [3:0]            digit_type;
   typedef logic [STAGE_BITS-1:0] chunk_type;
   typedef logic [WORD_W-1:0]     word_type;

   // Payload carried from one pipeline stage to the next.
   typedef struct packed {
      logic     zero;
      word_type bits;
      bcd_type  bcd;
   } stage_type;

   // Shift-add-3 conversion of one chunk, MSB first. Carries out of the top
   // digit are dropped, which keeps the value modulo ten to the fourteenth.
   function automatic bcd_type dabble_chunk(input bcd_type bcd_in, input chunk_type chunk);
      bcd_type acc;
      acc = bcd_in;
      for (int b = STAGE_BITS - 1; b >= 0; b--) begin
         for (int d = 0; d < DIGITS; d++) begin
            if (acc[4*d +: 4] >= 4'd5) begin
               acc[4*d +: 4] = acc[4*d +: 4] + 4'd3;
            end
         end
         acc = {acc[BCD_W-2:0], chunk[b]};
      end
      return acc;
   endfunction

   function automatic digit_type digit_at(input bcd_type bcd, input int pos);
      return bcd[4*pos +: 4];
   endfunction

   // True when every date and time group lies within its allowed range.
   function automatic logic datetime_in_range(input bcd_type bcd);
      digit_type sec_hi;
      digit_type min_hi;
      digit_type hour_hi;
      digit_type hour_lo;
      digit_type day_hi;
      digit_type day_lo;
      digit_type mon_hi;
      digit_type mon_lo;
      digit_type y0;
      digit_type y1;
      digit_type y2;
      digit_type y3;
      logic      ok_sec;
      logic      ok_min;
      logic      ok_hour;
      logic      ok_day;
      logic      ok_mon;
      logic      ok_year;
      sec_hi  = digit_at(bcd, SEC_POS + 1);
      min_hi  = digit_at(bcd, MIN_POS + 1);
      hour_lo = digit_at(bcd, HOUR_POS);
      hour_hi = digit_at(bcd, HOUR_POS + 1);
      day_lo  = digit_at(bcd, DAY_POS);
      day_hi  = digit_at(bcd, DAY_POS + 1);
      mon_lo  = digit_at(bcd, MONTH_POS);
      mon_hi  = digit_at(bcd, MONTH_POS + 1);
      y0      = digit_at(bcd, YEAR_POS);
      y1      = digit_at(bcd, YEAR_POS + 1);
      y2      = digit_at(bcd, YEAR_POS + 2);
      y3      = digit_at(bcd, YEAR_POS + 3);
      // Units digits are always 0-9, so only the tens digit limits 0-59.
      ok_sec  = (sec_hi <= 4'd5);
      ok_min  = (min_hi <= 4'd5);
      ok_hour = (hour_hi < 4'd2) || ((hour_hi == 4'd2) && (hour_lo <= 4'd3));
      ok_day  = (day_hi < 4'd3) || ((day_hi == 4'd3) && (day_lo <= 4'd1));
      ok_mon  = (mon_hi == 4'd0) || ((mon_hi == 4'd1) && (mon_lo <= 4'd2));
      // Year 1950 through 2050.
      ok_year = ((y3 == 4'd1) && (y2 == 4'd9) && (y1 >= 4'd5)) ||
                ((y3 == 4'd2) && (y2 == 4'd0) &&
                 ((y1 < 4'd5) || ((y1 == 4'd5) && (y0 == 4'd0))));
      return ok_sec && ok_min && ok_hour && ok_day && ok_mon && ok_year;
   endfunction

endpackage

>>> sv/packed_datetime_validator_top.sv
// ----------------------------------------------------------------------------
// packed_datetime_validator_top: pipelined packed decimal datetime check
//
// A new word can be started in every cycle: busy is never raised. Each
// transaction's result appears on rsp_valid_res with the one-cycle strobe
// rsp_valid, in the order the words were started. A word passes through one
// capture register, the eight binary-to-BCD conversion stages (eight input
// bits each) and one range-check register, in that order. The receiver has
// no way to hold results off.
// ----------------------------------------------------------------------------
module packed_datetime_validator_top
   import pdtv_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [WORD_W-1:0] req_raw_value,
   output logic              rsp_valid,
   output logic              rsp_valid_res
);

   // Stage 0 captures the masked word; stages 1..NUM_STAGES convert to BCD.
   logic      valid_ff [NUM_STAGES+1];
   stage_type data_ff  [NUM_STAGES+1];
   stage_type data_in  [NUM_STAGES+1];
   logic      valid_in [NUM_STAGES+1];

   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      rsp_res_ff;
   logic      rsp_res_in;

   // The pipeline never stalls, so a new transaction is always taken.
   assign busy = 1'b0;

   // Capture drops the sign marker and notes an all-zero value; the
   // conversion stages then shift the next chunk of bits into the BCD digits.
   always_comb begin
      valid_in[0]     = start && !busy;
      data_in[0].zero = (req_raw_value[SIGN_BIT-1:0] == '0);
      data_in[0].bits = {1'b0, req_raw_value[SIGN_BIT-1:0]};
      data_in[0].bcd  = '0;
      for (int s = 1; s <= NUM_STAGES; s++) begin
         valid_in[s]     = valid_ff[s-1];
         data_in[s].zero = data_ff[s-1].zero;
         data_in[s].bits = data_ff[s-1].bits << STAGE_BITS;
         data_in[s].bcd  = dabble_chunk(data_ff[s-1].bcd,
                                        data_ff[s-1].bits[WORD_W-1 -: STAGE_BITS]);
      end
   end

   // Final check on the fully converted digits.
   always_comb begin
      rsp_valid_in = valid_ff[NUM_STAGES];
      rsp_res_in   = data_ff[NUM_STAGES].zero ||
                     datetime_in_range(data_ff[NUM_STAGES].bcd);
   end

   // Valid bits travel with the data and are cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= NUM_STAGES; s++) begin
            valid_ff[s] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         for (int s = 0; s <= NUM_STAGES; s++) begin
            valid_ff[s] <= valid_in[s];
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      for (int s = 0; s <= NUM_STAGES; s++) begin
         data_ff[s] <= data_in[s];
      end
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_valid_res = rsp_res_ff;

endmodule

>>> sv/pdtv_checker.sv
// ----------------------------------------------------------------------------
// pdtv_checker: port-level checks for the datetime validator
//
// Watches only the top-level ports: every started transaction yields exactly
// one result after the fixed latency, and an all-zero value is reported valid.
// ----------------------------------------------------------------------------
module pdtv_checker
   import pdtv_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic [WORD_W-1:0] req_raw_value,
   input logic              rsp_valid,
   input logic              rsp_valid_res
);

   // The block accepts in every cycle, so it never signals busy.
   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      !busy)
      else $error("busy raised by a fully pipelined block");

   // Every accepted transaction yields a result after the fixed latency.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("accepted transaction produced no result");

   // No result appears without a transaction accepted the latency earlier.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result without a matching transaction");

   // A zero value (sign marker ignored) is always reported valid.
   a_zero_valid: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_raw_value[SIGN_BIT-1:0] == '0))
         |-> ##LATENCY (rsp_valid && rsp_valid_res))
      else $error("zero value not reported valid");

endmodule

bind packed_datetime_validator_top pdtv_checker u_pdtv_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_raw_value (req_raw_value),
   .rsp_valid     (rsp_valid),
   .rsp_valid_res (rsp_valid_res)
);

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for packed_datetime_validator_top
//
// Drives stored datetime words into the validator and compares every flag
// against a behavioral predictor. A short directed part covers the range
// limits of each date and time group, the zero word and the ignored high
// digits. A long random part follows, made mostly of well-formed datetimes
// with group values mostly in range or at the limits, plus raw noise words.
// ----------------------------------------------------------------------------
import pdtv_pkg::*;

// Holds the predicted flags of words in flight and checks each result.
class datetime_scoreboard;
   word_type pending_words[$];
   bit       pending_flags[$];
   int       failures;

   // Splits the masked word into decimal groups and applies each range.
   static function bit predict_valid(input word_type raw);
      longint unsigned rest;
      longint unsigned group_val;
      int              limits[5];
      limits = '{59, 59, 23, 31, 12};
      rest = raw;
      rest[SIGN_BIT] = 1'b0;
      if (rest == 0) begin
         return 1'b1;
      end
      // Seconds, minutes, hour, day and month, in that order from the right.
      foreach (limits[i]) begin
         group_val = rest % 100;
         rest = rest / 100;
         if (group_val > limits[i]) begin
            return 1'b0;
         end
      end
      group_val = rest % 10000;
      return (group_val >= 1950) && (group_val <= 2050);
   endfunction

   // Records an accepted transaction and its expected flag.
   function void note_word(input word_type raw);
      pending_words.push_back(raw);
      pending_flags.push_back(predict_valid(raw));
   endfunction

   // Compares one result strobe with the oldest expected flag.
   function void check_result(input bit actual);
      word_type raw;
      bit       expected;
      if (pending_flags.size() == 0) begin
         $display("%0t: unexpected result, expected none, actual %0b", $time, actual);
         failures++;
         return;
      end
      raw = pending_words.pop_front();
      expected = pending_flags.pop_front();
      if (actual !== expected) begin
         $display("%0t: valid_res mismatch for word %h: expected %0b, actual %0b",
                  $time, raw, expected, actual);
         failures++;
      end
   endfunction

   function int outstanding();
      return pending_flags.size();
   endfunction
endclass

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_WORDS = 1450;
   localparam int CYCLE_LIMIT  = 200000;

   logic     clock;
   logic     reset;
   logic     start;
   logic     busy;
   word_type req_raw_value;
   logic     rsp_valid;
   logic     rsp_valid_res;

   datetime_scoreboard scoreboard;
   int                 cycle_count;
   bit                 burst_mode;

   packed_datetime_validator_top dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_raw_value (req_raw_value),
      .rsp_valid     (rsp_valid),
      .rsp_valid_res (rsp_valid_res)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Every result strobe is taken at the edge that ends its cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         scoreboard.check_result(rsp_valid_res);
      end
   end

   // Watchdog: a run that hangs or loses results ends here.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAILURE");
      $finish;
   end

   // Presents one word after an idle gap and waits until it is taken.
   // Called and returns at a falling edge.
   task automatic drive_word(input word_type value, input int gap);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      start = 1'b1;
      req_raw_value = value;
      do begin
         @(posedge clock);
      end while (busy !== 1'b0);
      scoreboard.note_word(value);
      @(negedge clock);
   endtask

   // Holds the sender off until every outstanding result has come back.
   task automatic drain_results();
      start = 1'b0;
      while (scoreboard.outstanding() != 0) begin
         @(negedge clock);
      end
   endtask

   // Mostly in range, sometimes at or just past the limit, sometimes anything.
   function automatic longint unsigned random_group(input int limit);
      int pick;
      pick = $urandom_range(0, 9);
      if (pick <= 6) begin
         return 64'($urandom_range(0, limit));
      end else if (pick <= 8) begin
         return 64'($urandom_range(0, 1) ? limit : limit + 1);
      end
      return 64'($urandom_range(0, 99));
   endfunction

   function automatic longint unsigned random_year();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
         return 64'($urandom_range(1950, 2050));
      end else if (pick <= 7) begin
         case ($urandom_range(0, 3))
            0: return 64'd1949;
            1: return 64'd1950;
            2: return 64'd2050;
            default: return 64'd2051;
         endcase
      end
      return 64'($urandom_range(0, 9999));
   endfunction

   // Builds YYYYMMDDhhmmss with optional digits above the year; the prefix
   // bound keeps the whole number inside 63 bits.
   function automatic word_type random_datetime();
      longint unsigned value;
      value = ($urandom_range(0, 2) == 0) ? 64'($urandom_range(0, 92232)) : 64'd0;
      value = value * 10000 + random_year();
      value = value * 100 + random_group(12);
      value = value * 100 + random_group(31);
      value = value * 100 + random_group(23);
      value = value * 100 + random_group(59);
      value = value * 100 + random_group(59);
      value[SIGN_BIT] = 1'($urandom_range(0, 1));
      return value;
   endfunction

   function automatic word_type random_word();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 3) begin
         return {$urandom, $urandom};
      end else if (pick == 3) begin
         return {$urandom_range(0, 1) == 1, 53'd0, 10'($urandom_range(0, 999))};
      end
      return random_datetime();
   endfunction

   initial begin
      word_type directed_words[$];
      int       gap;

      scoreboard = new();
      burst_mode = 1'b0;
      start = 1'b0;
      req_raw_value = '0;
      reset = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Zero words, all-ones words and the limits of every group.
      directed_words = '{
         64'h0000_0000_0000_0000,
         64'h8000_0000_0000_0000,
         64'hFFFF_FFFF_FFFF_FFFF,
         64'h7FFF_FFFF_FFFF_FFFF,
         64'd1,
         64'd59,
         64'd19500101000000,
         64'd20501231235959,
         64'd20510101000000,
         64'd19491231235959,
         64'd20000101000060,
         64'd20000101006000,
         64'd20000101240000,
         64'd20000101230000,
         64'd20000132000000,
         64'd20000100000000,
         64'd20000010000000,
         64'd20001301000000,
         64'd20001231000000,
         64'd12320001231235959,
         64'd12320511231235959,
         64'h8000_0000_0000_0000 | 64'd12320001231235959
      };
      foreach (directed_words[i]) begin
         drive_word(directed_words[i], (i % 3 == 0) ? 0 : $urandom_range(0, 6));
      end
      drain_results();

      // Random part, alternating stretches of back-to-back and gapped traffic.
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 64 == 0) begin
            burst_mode = $urandom_range(0, 2) == 0;
         end
         if (n == RANDOM_WORDS / 2) begin
            drain_results();
         end
         gap = burst_mode ? 0 : $urandom_range(0, 6);
         drive_word(random_word(), gap);
      end
      start = 1'b0;

      while (scoreboard.outstanding() != 0) begin
         @(posedge clock);
      end
      repeat (LATENCY + 4) @(posedge clock);

      if (scoreboard.failures == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

>>> sim.f
sv/pdtv_pkg.sv
sv/packed_datetime_validator_top.sv
sv/pdtv_checker.sv
test/testbench.sv
